[src/ddee_pkg.sv]
`default_nettype none

package ddee_pkg;

    localparam int FRACTION_BITS    = 8;
    localparam int HALF_BASELINE_Q8 = 5683;

    localparam int FUNC_W     = 2;
    localparam int SPEED_W    = 16;
    localparam int LIMIT_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int TICK_W     = 11;
    localparam int POS_W      = 64;
    localparam int COUNT_W    = 32;
    localparam int PROD_W     = GAIN_W + SPEED_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TWIST_SHIFT = 8;
    localparam int TWIST_K_W   = 17;
    localparam int TWIST_P_W   = SPEED_W + TWIST_K_W;
    localparam int SUM_W       = TWIST_P_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_WHEEL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TWIST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_NEG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_NEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_POS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_POS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;

    localparam logic signed [LIMIT_W-1:0] RST_NEG_LIMIT = -8'sd100;
    localparam logic signed [LIMIT_W-1:0] RST_POS_LIMIT = 8'sd100;
    localparam logic signed [GAIN_W-1:0]  RST_GAIN      = -16'sd23193;
    localparam logic [TICK_W-1:0]         RST_TIMEOUT   = 11'd1010;

    typedef struct packed {
        logic signed [LIMIT_W-1:0] left_floor;
        logic signed [LIMIT_W-1:0] right_floor;
        logic signed [LIMIT_W-1:0] left_ceil;
        logic signed [LIMIT_W-1:0] right_ceil;
        logic signed [GAIN_W-1:0]  step_gain;
        logic [TICK_W-1:0]         timeout;
    } ddee_cfg_t;

    typedef struct packed {
        logic                      live;
        logic signed [POS_W-1:0]   left_acc;
        logic signed [POS_W-1:0]   right_acc;
        logic signed [SPEED_W-1:0] linear;
        logic signed [SPEED_W-1:0] turn;
    } ddee_rec_t;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SUM_W-1:0]   v,
        input logic signed [LIMIT_W-1:0] neg,
        input logic signed [LIMIT_W-1:0] pos
    );
        logic signed [SUM_W-1:0] neg_s;
        logic signed [SUM_W-1:0] pos_s;
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        neg_s = SUM_W'(neg);
        neg_s = neg_s <<< FRACTION_BITS;
        pos_s = SUM_W'(pos);
        pos_s = pos_s <<< FRACTION_BITS;
        hi = {{(SUM_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
        lo = {{(SUM_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};
        if (v > pos_s) begin
            r = pos_s;
        end else if (v < neg_s) begin
            r = neg_s;
        end else begin
            r = v;
        end
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return SPEED_W'(r);
    endfunction

endpackage

`default_nettype wire

[src/ddee_cfg.sv]
`default_nettype none

module ddee_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ddee_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ddee_pkg::CFG_DATA_W-1:0] cfg_data,
    output ddee_pkg::ddee_cfg_t                 cfg
);
    import ddee_pkg::*;

    ddee_cfg_t cfg_reg;
    ddee_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_LEFT_NEG:  cfg_next.left_floor  = LIMIT_W'(cfg_data);
                CFG_RIGHT_NEG: cfg_next.right_floor = LIMIT_W'(cfg_data);
                CFG_LEFT_POS:  cfg_next.left_ceil   = LIMIT_W'(cfg_data);
                CFG_RIGHT_POS: cfg_next.right_ceil  = LIMIT_W'(cfg_data);
                CFG_GAIN:      cfg_next.step_gain   = GAIN_W'(cfg_data);
                CFG_TIMEOUT:   cfg_next.timeout     = TICK_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_floor  <= RST_NEG_LIMIT;
            cfg_reg.right_floor <= RST_NEG_LIMIT;
            cfg_reg.left_ceil   <= RST_POS_LIMIT;
            cfg_reg.right_ceil  <= RST_POS_LIMIT;
            cfg_reg.step_gain   <= RST_GAIN;
            cfg_reg.timeout     <= RST_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/ddee_exec.sv]
`default_nettype none

module ddee_exec (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ddee_pkg::ddee_cfg_t               cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [ddee_pkg::FUNC_W-1:0]       in_func,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] in_left,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] in_right,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] in_lin,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] in_turn,
    output logic                                   rec_valid,
    input  wire logic                              rec_ready,
    output ddee_pkg::ddee_rec_t                    rec
);
    import ddee_pkg::*;

    localparam logic signed [TWIST_K_W-1:0] TWIST_LIN_GAIN  = -17'sd25600;
    localparam logic signed [TWIST_K_W-1:0] TWIST_TURN_GAIN = TWIST_K_W'(HALF_BASELINE_Q8);
    localparam logic [TICK_W-1:0]           TICK_SAT        = '1;

    logic signed [SPEED_W-1:0] left_vel_reg,  left_vel_next;
    logic signed [SPEED_W-1:0] right_vel_reg, right_vel_next;
    logic signed [SPEED_W-1:0] last_lin_reg,  last_lin_next;
    logic signed [SPEED_W-1:0] last_turn_reg, last_turn_next;
    logic signed [POS_W-1:0]   left_pos_reg,  left_pos_next;
    logic signed [POS_W-1:0]   right_pos_reg, right_pos_next;
    logic [TICK_W-1:0]         ticks_reg,     ticks_next;
    logic                      rec_valid_reg, rec_valid_next;
    ddee_rec_t                 rec_reg,       rec_next;

    logic signed [TWIST_P_W-1:0] lin_prod;
    logic signed [TWIST_P_W-1:0] turn_prod;
    logic signed [SUM_W-1:0]     left_sum;
    logic signed [SUM_W-1:0]     right_sum;
    logic signed [PROD_W-1:0]    left_step;
    logic signed [PROD_W-1:0]    right_step;
    logic                        go;

    assign in_ready  = (in_func != FUNC_TICK) || !rec_valid_reg || rec_ready;
    assign go        = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    always_comb begin
        lin_prod   = in_lin * TWIST_LIN_GAIN;
        turn_prod  = in_turn * TWIST_TURN_GAIN;
        left_sum   = (SUM_W'(lin_prod) - SUM_W'(turn_prod)) >>> TWIST_SHIFT;
        right_sum  = (SUM_W'(lin_prod) + SUM_W'(turn_prod)) >>> TWIST_SHIFT;
        left_step  = cfg.step_gain * left_vel_reg;
        right_step = cfg.step_gain * right_vel_reg;

        left_vel_next  = left_vel_reg;
        right_vel_next = right_vel_reg;
        last_lin_next  = last_lin_reg;
        last_turn_next = last_turn_reg;
        left_pos_next  = left_pos_reg;
        right_pos_next = right_pos_reg;
        ticks_next     = ticks_reg;
        rec_next       = rec_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;

        if (go) begin
            case (in_func)
                FUNC_WHEEL: begin
                    left_vel_next  = clamp_speed(SUM_W'(in_left), cfg.left_floor,
                                                 cfg.left_ceil);
                    right_vel_next = clamp_speed(SUM_W'(in_right), cfg.right_floor,
                                                 cfg.right_ceil);
                    ticks_next     = '0;
                end
                FUNC_TWIST: begin
                    last_lin_next  = in_lin;
                    last_turn_next = in_turn;
                    left_vel_next  = clamp_speed(left_sum, cfg.left_floor, cfg.left_ceil);
                    right_vel_next = clamp_speed(right_sum, cfg.right_floor, cfg.right_ceil);
                    ticks_next     = '0;
                end
                FUNC_TICK: begin
                    left_pos_next      = left_pos_reg + POS_W'(left_step);
                    right_pos_next     = right_pos_reg + POS_W'(right_step);
                    ticks_next         = (ticks_reg != TICK_SAT) ? ticks_reg + 1'b1 : ticks_reg;
                    rec_next.live      = ticks_reg < cfg.timeout;
                    rec_next.left_acc  = left_pos_next;
                    rec_next.right_acc = right_pos_next;
                    rec_next.linear    = last_lin_reg;
                    rec_next.turn      = last_turn_reg;
                    rec_valid_next     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_vel_reg  <= '0;
            right_vel_reg <= '0;
            last_lin_reg  <= '0;
            last_turn_reg <= '0;
            left_pos_reg  <= '0;
            right_pos_reg <= '0;
            ticks_reg     <= TICK_SAT;
            rec_valid_reg <= 1'b0;
        end else begin
            left_vel_reg  <= left_vel_next;
            right_vel_reg <= right_vel_next;
            last_lin_reg  <= last_lin_next;
            last_turn_reg <= last_turn_next;
            left_pos_reg  <= left_pos_next;
            right_pos_reg <= right_pos_next;
            ticks_reg     <= ticks_next;
            rec_valid_reg <= rec_valid_next;
        end
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

[src/ddee_out.sv]
`default_nettype none

module ddee_out (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                rec_valid,
    output logic                                     rec_ready,
    input  wire ddee_pkg::ddee_rec_t                 rec,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ddee_pkg::COUNT_W-1:0]      m_left_count,
    output logic signed [ddee_pkg::COUNT_W-1:0]      m_right_count,
    output logic signed [ddee_pkg::SPEED_W-1:0]      m_linear_echo,
    output logic signed [ddee_pkg::SPEED_W-1:0]      m_turn_echo
);
    import ddee_pkg::*;

    localparam int SHIFT = 2 * FRACTION_BITS;
    localparam int WIDE  = POS_W + 1;

    function automatic logic signed [COUNT_W-1:0] to_count(input logic signed [POS_W-1:0] p);
        logic signed [WIDE-1:0] t;
        logic signed [WIDE-1:0] n;
        logic signed [WIDE-1:0] hi;
        logic signed [WIDE-1:0] lo;
        hi = {{(WIDE-COUNT_W+1){1'b0}}, {(COUNT_W-1){1'b1}}};
        lo = {{(WIDE-COUNT_W+1){1'b1}}, {(COUNT_W-1){1'b0}}};
        t = WIDE'(p >>> SHIFT);
        if (p[POS_W-1] && (p[SHIFT-1:0] != '0)) begin
            t = t + WIDE'(1);
        end
        n = -t;
        if (n > hi) begin
            n = hi;
        end else if (n < lo) begin
            n = lo;
        end
        return COUNT_W'(n);
    endfunction

    logic                      m_valid_reg, m_valid_next;
    logic signed [COUNT_W-1:0] left_reg,    left_next;
    logic signed [COUNT_W-1:0] right_reg,   right_next;
    logic signed [SPEED_W-1:0] lin_reg,     lin_next;
    logic signed [SPEED_W-1:0] turn_reg,    turn_next;
    logic                      load;

    assign rec_ready     = !m_valid_reg || m_ready;
    assign load          = rec_valid && rec_ready;
    assign m_valid       = m_valid_reg;
    assign m_left_count  = left_reg;
    assign m_right_count = right_reg;
    assign m_linear_echo = lin_reg;
    assign m_turn_echo   = turn_reg;

    always_comb begin
        m_valid_next = rec_ready ? rec_valid : m_valid_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        lin_next     = lin_reg;
        turn_next    = turn_reg;
        if (load) begin
            left_next  = rec.live ? to_count(rec.left_acc) : '0;
            right_next = rec.live ? to_count(rec.right_acc) : '0;
            lin_next   = rec.linear;
            turn_next  = rec.turn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        left_reg  <= left_next;
        right_reg <= right_next;
        lin_reg   <= lin_next;
        turn_reg  <= turn_next;
    end

endmodule

`default_nettype wire

[src/diff_drive_encoder_emulator.sv]
// Two-wheel drive encoder emulator.
// Input channel (s_valid/s_ready) carries one beat per item: s_func 0 sets
// wheel speeds, 1 sets a twist (forward and turn rate), 2 is a time tick.
// Only a tick produces a result beat on the m_valid/m_ready channel: the
// negated wheel positions in whole counts (zero once the command timeout
// has run out) and the last twist.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while the block is idle.
// A tick passes the input register, the update stage and the count register
// in that order before its result shows on m_valid.
// Throughput: one item per cycle unless the receiver stalls; the update stage
// does one multiply-accumulate per wheel, the count register the count conversion.
// When the receiver stalls, ticks queue in the update and output stages;
// commands keep flowing until a tick meets a full update stage.
// Reset (aresetn low, synchronous) clears speeds, positions and the echo,
// marks the command timer expired and loads the default configuration.
`default_nettype none

module diff_drive_encoder_emulator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ddee_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ddee_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ddee_pkg::FUNC_W-1:0]         s_func,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] s_left_speed,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] s_right_speed,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] s_linear_rate,
    input  wire logic signed [ddee_pkg::SPEED_W-1:0] s_turn_rate,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [ddee_pkg::COUNT_W-1:0]      m_left_count,
    output logic signed [ddee_pkg::COUNT_W-1:0]      m_right_count,
    output logic signed [ddee_pkg::SPEED_W-1:0]      m_linear_echo,
    output logic signed [ddee_pkg::SPEED_W-1:0]      m_turn_echo
);
    import ddee_pkg::*;

    ddee_cfg_t cfg;
    ddee_rec_t rec;
    logic      rec_valid;
    logic      rec_ready;
    logic      exec_ready;

    logic                      in_valid_reg, in_valid_next;
    logic [FUNC_W-1:0]         in_func_reg;
    logic signed [SPEED_W-1:0] in_left_reg;
    logic signed [SPEED_W-1:0] in_right_reg;
    logic signed [SPEED_W-1:0] in_lin_reg;
    logic signed [SPEED_W-1:0] in_turn_reg;

    assign s_ready       = !in_valid_reg || exec_ready;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_func_reg  <= s_func;
            in_left_reg  <= s_left_speed;
            in_right_reg <= s_right_speed;
            in_lin_reg   <= s_linear_rate;
            in_turn_reg  <= s_turn_rate;
        end
    end

    ddee_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ddee_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (exec_ready),
        .in_func   (in_func_reg),
        .in_left   (in_left_reg),
        .in_right  (in_right_reg),
        .in_lin    (in_lin_reg),
        .in_turn   (in_turn_reg),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    ddee_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rec_valid     (rec_valid),
        .rec_ready     (rec_ready),
        .rec           (rec),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_count  (m_left_count),
        .m_right_count (m_right_count),
        .m_linear_echo (m_linear_echo),
        .m_turn_echo   (m_turn_echo)
    );

endmodule

`default_nettype wire
